>>> hw/rtl/esrp_pkg.sv
`timescale 1ns / 1ps

package esrp_pkg;

    localparam int unsigned TYPE_W   = 8;
    localparam int unsigned WORD_W   = 64;
    localparam int unsigned BYTES_W  = 4;
    localparam int unsigned NTYPES   = 56;

    localparam logic [TYPE_W-1:0] T_NONE     = 8'd0;
    localparam logic [TYPE_W-1:0] T_COPY     = 8'd19;
    localparam logic [TYPE_W-1:0] T_JMPSLOT  = 8'd21;
    localparam logic [TYPE_W-1:0] T_RELATIVE = 8'd22;

    localparam logic [BYTES_W-1:0] ACC_NONE = 4'd0;
    localparam logic [BYTES_W-1:0] ACC_HALF = 4'd2;
    localparam logic [BYTES_W-1:0] ACC_WORD = 4'd4;
    localparam logic [BYTES_W-1:0] ACC_DBL  = 4'd8;

    localparam logic [6:0] MASK_ALL = 7'd64;

    typedef enum logic [1:0] {
        ST_PATCHED = 2'd0,
        ST_SKIPPED = 2'd1,
        ST_UNKNOWN = 2'd2,
        ST_UNDEF   = 2'd3
    } esrp_status_t;

    // per-type decode: symbol/pc flags, right shift, field mask width, access width
    typedef struct packed {
        logic                sym;
        logic                pc;
        logic [5:0]          shift;
        logic [6:0]          mask_w;
        logic [BYTES_W-1:0]  bytes;
    } esrp_info_t;

    // what the merge stage needs
    typedef struct packed {
        esrp_status_t        status;
        logic [5:0]          shift;
        logic [6:0]          mask_w;
        logic [BYTES_W-1:0]  bytes;
    } esrp_ctl_t;

    function automatic esrp_info_t mk(input logic sym, input logic pc,
                                      input logic [5:0] sh, input logic [6:0] mw,
                                      input logic [BYTES_W-1:0] b);
        esrp_info_t r;
        r.sym    = sym;
        r.pc     = pc;
        r.shift  = sh;
        r.mask_w = mw;
        r.bytes  = b;
        return r;
    endfunction

    function automatic esrp_info_t type_info(input logic [5:0] t);
        esrp_info_t r;
        case (t)
            6'd1:  r = mk(1'b1, 1'b0, 6'd0,  7'd8,  ACC_WORD);
            6'd2:  r = mk(1'b1, 1'b0, 6'd0,  7'd16, ACC_WORD);
            6'd3:  r = mk(1'b1, 1'b0, 6'd0,  7'd32, ACC_WORD);
            6'd4:  r = mk(1'b1, 1'b1, 6'd0,  7'd8,  ACC_WORD);
            6'd5:  r = mk(1'b1, 1'b1, 6'd0,  7'd16, ACC_WORD);
            6'd6:  r = mk(1'b1, 1'b1, 6'd0,  7'd32, ACC_WORD);
            6'd7:  r = mk(1'b1, 1'b1, 6'd2,  7'd30, ACC_WORD);
            6'd8:  r = mk(1'b1, 1'b1, 6'd2,  7'd22, ACC_WORD);
            6'd9:  r = mk(1'b1, 1'b0, 6'd10, 7'd22, ACC_WORD);
            6'd10: r = mk(1'b1, 1'b0, 6'd0,  7'd22, ACC_WORD);
            6'd11: r = mk(1'b1, 1'b0, 6'd0,  7'd13, ACC_WORD);
            6'd12: r = mk(1'b1, 1'b0, 6'd0,  7'd10, ACC_WORD);
            6'd13: r = mk(1'b0, 1'b0, 6'd0,  7'd10, ACC_WORD);
            6'd14: r = mk(1'b0, 1'b0, 6'd0,  7'd13, ACC_WORD);
            6'd15: r = mk(1'b0, 1'b0, 6'd10, 7'd22, ACC_WORD);
            6'd16: r = mk(1'b1, 1'b1, 6'd0,  7'd10, ACC_WORD);
            6'd17: r = mk(1'b1, 1'b1, 6'd10, 7'd22, ACC_WORD);
            6'd18: r = mk(1'b0, 1'b1, 6'd2,  7'd30, ACC_WORD);
            6'd20: r = mk(1'b1, 1'b0, 6'd0,  7'd32, ACC_DBL);
            // relative: load_base + addend, full word
            6'd22: r = mk(1'b0, 1'b0, 6'd0,  MASK_ALL, ACC_DBL);
            6'd23: r = mk(1'b1, 1'b0, 6'd0,  7'd32, ACC_WORD);
            6'd24: r = mk(1'b0, 1'b0, 6'd0,  7'd32, ACC_WORD);
            6'd25: r = mk(1'b0, 1'b0, 6'd10, 7'd22, ACC_WORD);
            6'd26: r = mk(1'b0, 1'b0, 6'd0,  7'd10, ACC_WORD);
            6'd27: r = mk(1'b0, 1'b1, 6'd0,  7'd32, ACC_WORD);
            6'd28: r = mk(1'b0, 1'b1, 6'd10, 7'd22, ACC_WORD);
            6'd29: r = mk(1'b0, 1'b1, 6'd0,  7'd10, ACC_WORD);
            6'd30: r = mk(1'b1, 1'b0, 6'd0,  7'd10, ACC_WORD);
            6'd31: r = mk(1'b1, 1'b0, 6'd0,  7'd11, ACC_WORD);
            6'd32: r = mk(1'b1, 1'b0, 6'd0,  MASK_ALL, ACC_DBL);
            6'd33: r = mk(1'b1, 1'b0, 6'd0,  7'd10, ACC_WORD);
            6'd34: r = mk(1'b1, 1'b0, 6'd42, 7'd22, ACC_WORD);
            6'd35: r = mk(1'b1, 1'b0, 6'd32, 7'd10, ACC_WORD);
            6'd36: r = mk(1'b1, 1'b0, 6'd10, 7'd22, ACC_WORD);
            6'd37: r = mk(1'b1, 1'b1, 6'd42, 7'd22, ACC_WORD);
            6'd38: r = mk(1'b1, 1'b1, 6'd32, 7'd10, ACC_WORD);
            6'd39: r = mk(1'b1, 1'b1, 6'd10, 7'd22, ACC_WORD);
            6'd40: r = mk(1'b1, 1'b1, 6'd2,  7'd16, ACC_WORD);
            6'd41: r = mk(1'b1, 1'b1, 6'd2,  7'd19, ACC_WORD);
            6'd42: r = mk(1'b1, 1'b0, 6'd0,  MASK_ALL, ACC_WORD);
            6'd43: r = mk(1'b1, 1'b0, 6'd0,  7'd7,  ACC_WORD);
            6'd44: r = mk(1'b1, 1'b0, 6'd0,  7'd5,  ACC_WORD);
            6'd45: r = mk(1'b1, 1'b0, 6'd0,  7'd6,  ACC_WORD);
            6'd46: r = mk(1'b1, 1'b1, 6'd0,  MASK_ALL, ACC_DBL);
            6'd47: r = mk(1'b0, 1'b0, 6'd0,  MASK_ALL, ACC_DBL);
            6'd48: r = mk(1'b1, 1'b0, 6'd10, 7'd22, ACC_WORD);
            6'd49: r = mk(1'b1, 1'b0, 6'd0,  7'd13, ACC_WORD);
            6'd50: r = mk(1'b1, 1'b0, 6'd22, 7'd22, ACC_WORD);
            6'd51: r = mk(1'b1, 1'b0, 6'd12, 7'd10, ACC_WORD);
            6'd52: r = mk(1'b1, 1'b0, 6'd0,  7'd13, ACC_WORD);
            6'd53: r = mk(1'b1, 1'b0, 6'd0,  MASK_ALL, ACC_DBL);
            6'd54: r = mk(1'b1, 1'b0, 6'd0,  MASK_ALL, ACC_DBL);
            6'd55: r = mk(1'b1, 1'b0, 6'd0,  7'd16, ACC_HALF);
            // codes with no entry here (skipped or out of table) get no fields and no access width
            default: r = mk(1'b0, 1'b0, 6'd0, 7'd0, ACC_NONE);
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/elf_sparc_relocation_patch_core.sv
`timescale 1ns / 1ps
// SPARC64 ELF relocation patch engine.
// Input channel (s_*): one relocation request per beat: type, target offset,
//   addend, resolved symbol address with found flag, and the old contents at
//   the target, right aligned.
// Output channel (m_*): one result per request, in order: patched contents,
//   access width in bytes (0, 2, 4 or 8) and a status (patched, skipped,
//   unknown type, undefined symbol).
// Config channel (cfg_*): writes load_base; cfg_ready is always high. Write it
//   only while no request is in flight.
// Throughput is one request per cycle while the output is not stalled: three
//   register stages (decode and sums, PC-relative subtract, shift/mask/merge
//   into the output register); m_valid rises when a request reaches the third.
// Each stage has its own valid bit and takes new data whenever it is empty or
//   the stage after it moves, so a stalled m_ready only backs up the pipe as
//   far as it is full; bubbles are squeezed out and nothing is dropped.
// Reset (aresetn low, synchronous) empties the pipe and clears load_base.
module elf_sparc_relocation_patch_core (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [63:0]        cfg_wdata,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_reloc_type,
    input  logic [63:0]        s_target_offset,
    input  logic signed [63:0] s_addend,
    input  logic [63:0]        s_symbol_address,
    input  logic               s_symbol_found,
    input  logic [63:0]        s_old_contents,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [63:0]        m_new_contents,
    output logic [3:0]         m_access_bytes,
    output logic [1:0]         m_status
);
    import esrp_pkg::*;

    logic [63:0] load_base_reg;

    // stage 1
    logic        v1_reg;
    esrp_ctl_t   ctl1_reg, ctl1_next;
    logic        pc1_reg, pc1_next;
    logic [63:0] sum1_reg, sum1_next;
    logic [63:0] pcb1_reg, pcb1_next;
    logic [63:0] old1_reg;

    // stage 2
    logic        v2_reg;
    esrp_ctl_t   ctl2_reg;
    logic [63:0] val2_reg, val2_next;
    logic [63:0] old2_reg;

    // stage 3 (output)
    logic        v3_reg;
    logic [63:0] new3_reg, new3_next;
    logic [3:0]  acc3_reg, acc3_next;
    logic [1:0]  st3_reg;

    logic rdy1, rdy2, rdy3;
    esrp_info_t info;
    logic [63:0] sym_sel;

    assign cfg_ready = 1'b1;

    assign rdy3    = !v3_reg || m_ready;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_base_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            load_base_reg <= cfg_wdata;
        end
    end

    // decode, addend + symbol (or base for relative), base + offset
    always_comb begin
        info = type_info(s_reloc_type[5:0]);
        ctl1_next.shift  = info.shift;
        ctl1_next.mask_w = info.mask_w;
        ctl1_next.bytes  = info.bytes;
        pc1_next         = info.pc;

        if (s_reloc_type == T_NONE || s_reloc_type == T_COPY ||
            s_reloc_type == T_JMPSLOT) begin
            ctl1_next.status = ST_SKIPPED;
        end else if (s_reloc_type >= TYPE_W'(NTYPES)) begin
            ctl1_next.status = ST_UNKNOWN;
        end else if (info.sym && !s_symbol_found) begin
            ctl1_next.status = ST_UNDEF;
        end else begin
            ctl1_next.status = ST_PATCHED;
        end

        if (s_reloc_type == T_RELATIVE) begin
            sym_sel = load_base_reg;
        end else if (info.sym) begin
            sym_sel = s_symbol_address;
        end else begin
            sym_sel = '0;
        end

        sum1_next = $unsigned(s_addend) + sym_sel;
        pcb1_next = load_base_reg + s_target_offset;
    end

    assign val2_next = pc1_reg ? (sum1_reg - pcb1_reg) : sum1_reg;

    esrp_merge u_merge (
        .ctl          (ctl2_reg),
        .value        (val2_reg),
        .old_contents (old2_reg),
        .new_contents (new3_next),
        .access_bytes (acc3_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && rdy1) begin
            ctl1_reg <= ctl1_next;
            pc1_reg  <= pc1_next;
            sum1_reg <= sum1_next;
            pcb1_reg <= pcb1_next;
            old1_reg <= s_old_contents;
        end
        if (v1_reg && rdy2) begin
            ctl2_reg <= ctl1_reg;
            val2_reg <= val2_next;
            old2_reg <= old1_reg;
        end
        if (v2_reg && rdy3) begin
            new3_reg <= new3_next;
            acc3_reg <= acc3_next;
            st3_reg  <= ctl2_reg.status;
        end
    end

    assign m_valid        = v3_reg;
    assign m_new_contents = new3_reg;
    assign m_access_bytes = acc3_reg;
    assign m_status       = st3_reg;

endmodule

>>> hw/rtl/esrp_merge.sv
`timescale 1ns / 1ps

module esrp_merge (
    input  esrp_pkg::esrp_ctl_t  ctl,
    input  logic [63:0]          value,
    input  logic [63:0]          old_contents,
    output logic [63:0]          new_contents,
    output logic [3:0]           access_bytes
);
    import esrp_pkg::*;

    logic [63:0] field_mask;
    logic [63:0] keep;
    logic [63:0] shifted;

    always_comb begin
        if (ctl.mask_w[6]) begin
            field_mask = '1;
        end else begin
            field_mask = (64'd1 << ctl.mask_w[5:0]) - 64'd1;
        end

        case (ctl.bytes)
            ACC_HALF: keep = {48'd0, 16'hffff};
            ACC_WORD: keep = {32'd0, 32'hffff_ffff};
            ACC_DBL:  keep = '1;
            default:  keep = '0;
        endcase

        shifted = (value >> ctl.shift) & field_mask;

        if (ctl.status == ST_PATCHED) begin
            new_contents = ((old_contents & keep & ~field_mask) | shifted) & keep;
            access_bytes = ctl.bytes;
        end else begin
            new_contents = '0;
            access_bytes = ACC_NONE;
        end
    end

endmodule

>>> hw/rtl/esrp_checker.sv
`timescale 1ns / 1ps

module esrp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_new_contents,
    input logic [3:0]  m_access_bytes,
    input logic [1:0]  m_status
);
    import esrp_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_new_contents) &&
            $stable(m_access_bytes) && $stable(m_status))
        else $error("result changed while stalled");

    // anything but a patch writes nothing
    a_nowrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_PATCHED |->
            m_access_bytes == ACC_NONE && m_new_contents == 64'd0)
        else $error("non-patched result carries data");

    // a patch has a real access width and nothing above it
    a_width: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_PATCHED |->
            (m_access_bytes == ACC_HALF && m_new_contents[63:16] == 48'd0) ||
            (m_access_bytes == ACC_WORD && m_new_contents[63:32] == 32'd0) ||
            m_access_bytes == ACC_DBL)
        else $error("bad access width on patch");

    // pipe is empty after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // with the output stalled, input is refused once the pipe is full
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready && !s_ready |=> !s_ready || m_ready || !m_valid)
        else $error("input taken while pipe full and stalled");

endmodule

bind elf_sparc_relocation_patch_core esrp_checker u_esrp_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_new_contents (m_new_contents),
    .m_access_bytes (m_access_bytes),
    .m_status       (m_status)
);
